FILE: hw/rtl/huffman_tree_decoder_unit_macros.svh
// Assertion macros for the Huffman tree decoder unit.
// Depends on nothing; included by the modules that carry assertions.
`ifndef HUFFMAN_TREE_DECODER_UNIT_MACROS_SVH
`define HUFFMAN_TREE_DECODER_UNIT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define HTD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define HTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/htd_pkg.sv
// Shared types and constants of the Huffman tree decoder unit.
// Depends on nothing; used by the result interface, the controller, the datapath and the top.
package htd_pkg;

	localparam int NODE_COUNT_DEF   = 512;
	localparam int MAX_CODE_LEN_DEF = 32;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_DATA = 1'b1;

	typedef enum logic [2:0] {
		ST_SYMBOL    = 3'd0,
		ST_LOADED    = 3'd1,
		ST_POOL_FULL = 3'd2,
		ST_BAD_LEN   = 3'd3,
		ST_INVALID   = 3'd4
	} status_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic    accept;
		logic    clr_wr;
		logic    ld_init;
		logic    ld_step;
		logic    ld_leaf;
		logic    dc_start;
		logic    dc_go;
		logic    dc_invalid;
		logic    dc_leaf;
		logic    dc_descend;
		logic    push;
		logic    flush;
		status_t res_status;
	} ctrl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic clr_done;
		logic is_load;
		logic len_bad;
		logic ld_last;
		logic ld_full_hit;
		logic dc_done;
		logic nxt_zero;
		logic nxt_leaf;
		logic b_zero;
		logic count_hits;
		logic room;
		logic out_free;
		logic pend_v;
	} dp_stat_t;

endpackage

FILE: hw/rtl/htd_if.sv
// Channel interfaces of the Huffman tree decoder unit: request, result, config.
// Depends on htd_pkg.
interface htd_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [7:0]  entry_symbol;
	logic [5:0]  code_length;
	logic [31:0] code_value;
	logic [7:0]  data_byte;

	modport source (output valid, req_type, entry_symbol, code_length, code_value,
		data_byte, input ready);
	modport sink (input valid, req_type, entry_symbol, code_length, code_value,
		data_byte, output ready);
endinterface

interface htd_res_if;
	logic             valid;
	logic             ready;
	htd_pkg::status_t status;
	logic [7:0]       out_symbol;
	logic             last;
	logic             finished;

	modport source (output valid, status, out_symbol, last, finished, input ready);
	modport sink (input valid, status, out_symbol, last, finished, output ready);
endinterface

interface htd_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: hw/rtl/htd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module htd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, hold data when idle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: hw/rtl/htd_datapath.sv
// Datapath of the Huffman tree decoder: node table, walk registers, result stages.
// Depends on htd_pkg, htd_ram and the assertion macro header.
`include "huffman_tree_decoder_unit_macros.svh"

module htd_datapath #(
	parameter int NODE_COUNT   = htd_pkg::NODE_COUNT_DEF,
	parameter int MAX_CODE_LEN = htd_pkg::MAX_CODE_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  htd_pkg::ctrl_cmd_t cmd,
	output htd_pkg::dp_stat_t  st,
	input  logic               in_req_type,
	input  logic [7:0]         in_entry_symbol,
	input  logic [5:0]         in_code_length,
	input  logic [31:0]        in_code_value,
	input  logic [7:0]         in_data_byte,
	input  logic               cfg_wr,
	input  logic [31:0]        cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output htd_pkg::status_t   out_status,
	output logic [7:0]         out_symbol,
	output logic               out_last,
	output logic               out_finished
);

	localparam int IDX_W  = $clog2(NODE_COUNT);
	localparam int NF_W   = $clog2(NODE_COUNT + 1);
	localparam int NODE_W = 2 * IDX_W + 9;

	typedef struct packed {
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic [7:0]       sym;
		logic             leaf;
	} node_t;

	// Item registers
	logic        type_q;
	logic [7:0]  sym_q;
	logic [5:0]  len_q;
	logic [31:0] code_q;
	logic [7:0]  byte_q;

	// Walk state
	logic [NF_W-1:0]  next_free_q;
	logic [IDX_W-1:0] walk_q;
	logic [IDX_W-1:0] ld_node_q;
	logic [IDX_W-1:0] nxt_q;
	logic [IDX_W-1:0] clr_q;
	logic [5:0]       i_q;
	logic [2:0]       b_q;
	logic [31:0]      count_q;
	logic [31:0]      olen_q;

	// Result stages
	logic             pend_v_q;
	htd_pkg::status_t pend_status_q;
	logic [7:0]       pend_sym_q;
	logic             pend_fin_q;
	logic             out_v_q;
	htd_pkg::status_t out_status_q;
	logic [7:0]       out_sym_q;
	logic             out_last_q;
	logic             out_fin_q;

	// RAM signals
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	node_t             wr_node;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic [NODE_W-1:0] rd_data;
	node_t             rd_node;

	logic [5:0]       ld_bit_idx;
	logic             ld_bit;
	logic [IDX_W-1:0] ld_slot;
	logic             ld_alloc;
	logic             pool_full;
	logic [IDX_W-1:0] ld_next;
	logic             dc_bit;
	logic [IDX_W-1:0] dc_nxt;
	logic [32:0]      count_inc;
	logic             count_ge;
	logic             count_hits;
	logic             out_free;
	logic             move_out;
	logic             new_fin;
	logic [7:0]       new_sym;

	htd_ram #(
		.WIDTH(NODE_W),
		.DEPTH(NODE_COUNT)
	) u_node_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_node),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_node = node_t'(rd_data);

	// Load walk: pick the code bit, the child slot and any allocation
	assign ld_bit_idx = i_q - 6'd1;
	assign ld_bit     = ld_bit_idx[5] ? 1'b0 : code_q[ld_bit_idx[4:0]];
	assign ld_slot    = ld_bit ? rd_node.right : rd_node.left;
	assign ld_alloc   = (ld_slot == '0);
	assign pool_full  = (next_free_q >= NF_W'(NODE_COUNT));
	assign ld_next    = ld_alloc ? next_free_q[IDX_W-1:0] : ld_slot;

	// Decode walk: pick the data bit and the child
	assign dc_bit = byte_q[b_q];
	assign dc_nxt = dc_bit ? rd_node.right : rd_node.left;

	assign count_inc  = {1'b0, count_q} + 33'd1;
	assign count_ge   = (count_q >= olen_q);
	assign count_hits = (count_inc >= {1'b0, olen_q});

	assign out_free = !out_v_q || out_ready;
	assign move_out = (cmd.push || cmd.flush) && pend_v_q;
	assign new_fin  = (cmd.res_status == htd_pkg::ST_SYMBOL) ? count_hits : count_ge;
	assign new_sym  = (cmd.res_status == htd_pkg::ST_SYMBOL) ? rd_node.sym : 8'd0;

	// Node table write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ld_node_q;
		wr_node = rd_node;
		if (cmd.clr_wr) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_node = '0;
		end else if (cmd.ld_step && ld_alloc) begin
			wr_en = 1'b1;
			if (ld_bit) begin
				wr_node.right = next_free_q[IDX_W-1:0];
			end else begin
				wr_node.left = next_free_q[IDX_W-1:0];
			end
		end else if (cmd.ld_leaf) begin
			wr_en        = 1'b1;
			wr_node.sym  = sym_q;
			wr_node.leaf = 1'b1;
		end
	end

	// Node table read port
	always_comb begin
		rd_en   = 1'b1;
		rd_addr = '0;
		if (cmd.ld_step) begin
			rd_addr = ld_next;
		end else if (cmd.dc_start) begin
			rd_addr = walk_q;
		end else if (cmd.dc_go) begin
			rd_addr = dc_nxt;
		end else if (!(cmd.ld_init || cmd.dc_invalid || cmd.dc_leaf)) begin
			rd_en = 1'b0;
		end
	end

	// Latch the accepted item
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			type_q <= in_req_type;
			sym_q  <= in_entry_symbol;
			len_q  <= in_code_length;
			code_q <= in_code_value;
			byte_q <= in_data_byte;
		end
	end

	// Advance walk counters
	always_ff @(posedge clk) begin
		if (cmd.ld_init) begin
			ld_node_q <= '0;
			i_q       <= len_q;
		end else if (cmd.ld_step) begin
			ld_node_q <= ld_next;
			i_q       <= i_q - 6'd1;
		end
		if (cmd.dc_start) begin
			b_q <= 3'd7;
		end else if (cmd.dc_invalid || cmd.dc_leaf || cmd.dc_descend) begin
			b_q <= b_q - 3'd1;
		end
		if (cmd.dc_go) begin
			nxt_q <= dc_nxt;
		end
	end

	// Hold tree, walk, count and config state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_free_q <= NF_W'(1);
			walk_q      <= '0;
			count_q     <= '0;
			olen_q      <= '0;
			clr_q       <= '0;
		end else begin
			if (cfg_wr) begin
				olen_q <= cfg_data;
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.ld_step && ld_alloc) begin
				next_free_q <= next_free_q + 1'b1;
			end
			if (cmd.dc_invalid || cmd.dc_leaf) begin
				walk_q <= '0;
			end else if (cmd.dc_descend) begin
				walk_q <= nxt_q;
			end
			if (cmd.dc_leaf) begin
				count_q <= count_inc[31:0];
			end
		end
	end

	// Result valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (move_out) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			if (cmd.push) begin
				pend_v_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// Result payload: pending stage feeds the output stage
	always_ff @(posedge clk) begin
		if (move_out) begin
			out_status_q <= pend_status_q;
			out_sym_q    <= pend_sym_q;
			out_fin_q    <= pend_fin_q;
			out_last_q   <= cmd.flush;
		end
		if (cmd.push) begin
			pend_status_q <= cmd.res_status;
			pend_sym_q    <= new_sym;
			pend_fin_q    <= new_fin;
		end
	end

	assign out_valid    = out_v_q;
	assign out_status   = out_status_q;
	assign out_symbol   = out_sym_q;
	assign out_last     = out_last_q;
	assign out_finished = out_fin_q;

	// Status to the controller
	always_comb begin
		st.clr_done    = (clr_q == IDX_W'(NODE_COUNT - 1));
		st.is_load     = (type_q == htd_pkg::REQ_LOAD);
		st.len_bad     = (len_q == 6'd0) || ({1'b0, len_q} > 7'(MAX_CODE_LEN));
		st.ld_last     = (i_q == 6'd1);
		st.ld_full_hit = ld_alloc && pool_full;
		st.dc_done     = count_ge;
		st.nxt_zero    = (dc_nxt == '0);
		st.nxt_leaf    = rd_node.leaf;
		st.b_zero      = (b_q == 3'd0);
		st.count_hits  = count_hits;
		st.room        = !pend_v_q || out_free;
		st.out_free    = out_free;
		st.pend_v      = pend_v_q;
	end

	`HTD_ASSERT_NOW(a_push_room, clk, arst_n, cmd.push && pend_v_q, out_free, "push over full output")
	`HTD_ASSERT_NOW(a_flush_room, clk, arst_n, cmd.flush && pend_v_q, out_free, "flush over full output")
	`HTD_ASSERT_NOW(a_step_pool, clk, arst_n, cmd.ld_step, !(ld_alloc && pool_full), "alloc from full pool")
	`HTD_ASSERT_NEXT(a_alloc_inc, clk, arst_n, cmd.ld_step && ld_alloc, next_free_q == $past(next_free_q) + 1'b1, "free pointer slip")

endmodule

FILE: hw/rtl/htd_ctrl.sv
// Controller of the Huffman tree decoder: sequences clearing, loads and decodes.
// Depends on htd_pkg.
module htd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  htd_pkg::dp_stat_t  st,
	output htd_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_BADLEN,
		S_LD_STEP,
		S_LD_LEAF,
		S_DC_STEP,
		S_DC_CHK,
		S_FLUSH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   in_ready_q;

	// Next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (st.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid && in_ready_q) begin
					cmd.accept = 1'b1;
					state_d    = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (st.is_load) begin
					if (st.len_bad) begin
						state_d = S_BADLEN;
					end else begin
						cmd.ld_init = 1'b1;
						state_d     = S_LD_STEP;
					end
				end else if (st.dc_done) begin
					state_d = S_IDLE;
				end else begin
					cmd.dc_start = 1'b1;
					state_d      = S_DC_STEP;
				end
			end
			S_BADLEN: begin
				if (st.room) begin
					cmd.push       = 1'b1;
					cmd.res_status = htd_pkg::ST_BAD_LEN;
					state_d        = S_FLUSH;
				end
			end
			S_LD_STEP: begin
				if (st.ld_full_hit) begin
					if (st.room) begin
						cmd.push       = 1'b1;
						cmd.res_status = htd_pkg::ST_POOL_FULL;
						state_d        = S_FLUSH;
					end
				end else begin
					cmd.ld_step = 1'b1;
					if (st.ld_last) begin
						state_d = S_LD_LEAF;
					end
				end
			end
			S_LD_LEAF: begin
				if (st.room) begin
					cmd.ld_leaf    = 1'b1;
					cmd.push       = 1'b1;
					cmd.res_status = htd_pkg::ST_LOADED;
					state_d        = S_FLUSH;
				end
			end
			S_DC_STEP: begin
				if (st.nxt_zero) begin
					if (st.room) begin
						cmd.push       = 1'b1;
						cmd.res_status = htd_pkg::ST_INVALID;
						cmd.dc_invalid = 1'b1;
						if (st.b_zero) begin
							state_d = S_FLUSH;
						end
					end
				end else begin
					cmd.dc_go = 1'b1;
					state_d   = S_DC_CHK;
				end
			end
			S_DC_CHK: begin
				if (st.nxt_leaf) begin
					if (st.room) begin
						cmd.push       = 1'b1;
						cmd.res_status = htd_pkg::ST_SYMBOL;
						cmd.dc_leaf    = 1'b1;
						state_d        = (st.b_zero || st.count_hits) ? S_FLUSH : S_DC_STEP;
					end
				end else begin
					cmd.dc_descend = 1'b1;
					state_d        = st.b_zero ? S_FLUSH : S_DC_STEP;
				end
			end
			S_FLUSH: begin
				if (!st.pend_v) begin
					state_d = S_IDLE;
				end else if (st.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state and the registered ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			in_ready_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			in_ready_q <= (state_d == S_IDLE);
		end
	end

	assign in_ready = in_ready_q;

endmodule

FILE: hw/rtl/huffman_tree_decoder_unit.sv
// Top level of the Huffman tree decoder unit: controller plus datapath.
// Depends on htd_pkg, htd_if, htd_ctrl and htd_datapath.
//
//  Channel  Dir  Handshake     Transaction
//  req      in   valid/ready   load entry (req_type 0) or compressed byte (1)
//  res      out  valid/ready   one result: status, out_symbol, last, finished
//  cfg      in   valid/ready   write of output_length (ready always high)
//
// After reset the node table is cleared, one entry a cycle, until every entry is
// zero; no request is taken during that pass, config writes are.
// A load walks one node per code bit, then writes the leaf; a bad length only posts its result.
// A byte reads the child and then checks for a leaf for each bit, with only the read for a
// missing child; once decoding has finished a byte is dropped, and it may stop mid-byte.
// A stalled result channel holds the walk at the next result it produces.
module huffman_tree_decoder_unit #(
	parameter int NODE_COUNT   = htd_pkg::NODE_COUNT_DEF,
	parameter int MAX_CODE_LEN = htd_pkg::MAX_CODE_LEN_DEF
) (
	input logic        clk,
	input logic        arst_n,
	htd_req_if.sink    req,
	htd_res_if.source  res,
	htd_cfg_if.sink    cfg
);

	htd_pkg::ctrl_cmd_t cmd;
	htd_pkg::dp_stat_t  st;

	assign cfg.ready = 1'b1;

	htd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.st       (st),
		.cmd      (cmd)
	);

	htd_datapath #(
		.NODE_COUNT   (NODE_COUNT),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.in_req_type     (req.req_type),
		.in_entry_symbol (req.entry_symbol),
		.in_code_length  (req.code_length),
		.in_code_value   (req.code_value),
		.in_data_byte    (req.data_byte),
		.cfg_wr          (cfg.valid && cfg.ready),
		.cfg_data        (cfg.data),
		.out_valid       (res.valid),
		.out_ready       (res.ready),
		.out_status      (res.status),
		.out_symbol      (res.out_symbol),
		.out_last        (res.last),
		.out_finished    (res.finished)
	);

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for huffman_tree_decoder_unit: table loads and byte decoding.
// Depends on htd_pkg and the htd_if channel interfaces of the RTL.
module testbench;
	import htd_pkg::*;

	localparam int NODE_COUNT   = NODE_COUNT_DEF;
	localparam int MAX_CODE_LEN = MAX_CODE_LEN_DEF;
	localparam int RANDOM_ITEMS = 340;
	localparam int DRAIN_CYCLES = 64;
	localparam int MAX_SHOWN    = 10;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  entry_symbol;
		logic [5:0]  code_length;
		logic [31:0] code_value;
		logic [7:0]  data_byte;
	} htd_request_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] out_symbol;
		logic       last;
		logic       finished;
	} htd_result_t;

	// Decode tree mirror plus the queue of results the block still owes
	class htd_scoreboard;
		int unsigned left_child [NODE_COUNT];
		int unsigned right_child [NODE_COUNT];
		bit [7:0]    node_symbol [NODE_COUNT];
		bit          node_is_leaf [NODE_COUNT];
		int unsigned free_node;
		int unsigned walk_node;
		int unsigned decoded_count;
		int unsigned output_length;
		htd_result_t item_batch [$];
		htd_result_t expected_results [$];
		int          error_count;
		int          checked_count;
		int          status_seen [5];
		int          pool_full_predicted;

		function new();
			free_node = 1;
			walk_node = 0;
			decoded_count = 0;
			output_length = 0;
			error_count = 0;
			checked_count = 0;
			pool_full_predicted = 0;
			foreach (status_seen[i])
				status_seen[i] = 0;
		endfunction

		function void set_output_length(logic [31:0] value);
			output_length = value;
		endfunction

		function int outstanding();
			return expected_results.size();
		endfunction

		function void stage_result(status_t st, logic [7:0] sym);
			htd_result_t r;
			r.status = st;
			r.out_symbol = sym;
			r.last = 1'b0;
			r.finished = (decoded_count >= output_length);
			item_batch.push_back(r);
		endfunction

		// Walk the code from the root, allocating missing nodes
		function status_t insert_code(logic [7:0] sym, int unsigned len, logic [31:0] code);
			int unsigned node;
			int unsigned child;
			logic dir;
			if (len == 0 || len > MAX_CODE_LEN)
				return ST_BAD_LEN;
			node = 0;
			for (int i = len - 1; i >= 0; i--) begin
				dir = code[i];
				child = dir ? right_child[node] : left_child[node];
				if (child == 0) begin
					if (free_node >= NODE_COUNT)
						return ST_POOL_FULL;
					child = free_node;
					free_node++;
					if (dir)
						right_child[node] = child;
					else
						left_child[node] = child;
				end
				node = child;
			end
			node_symbol[node] = sym;
			node_is_leaf[node] = 1'b1;
			return ST_LOADED;
		endfunction

		// Predict the results of one accepted transaction
		function void note_request(htd_request_t r);
			status_t st;
			int unsigned nxt;
			logic dir;
			item_batch.delete();
			if (r.req_type == REQ_LOAD) begin
				st = insert_code(r.entry_symbol, 32'(r.code_length), r.code_value);
				if (st == ST_POOL_FULL)
					pool_full_predicted++;
				stage_result(st, 8'h00);
			end else begin
				for (int b = 7; b >= 0 && decoded_count < output_length; b--) begin
					dir = r.data_byte[b];
					nxt = dir ? right_child[walk_node] : left_child[walk_node];
					if (nxt == 0) begin
						walk_node = 0;
						stage_result(ST_INVALID, 8'h00);
					end else if (node_is_leaf[nxt]) begin
						decoded_count++;
						walk_node = 0;
						stage_result(ST_SYMBOL, node_symbol[nxt]);
					end else begin
						walk_node = nxt;
					end
				end
			end
			// Flag the final result of this transaction
			if (item_batch.size() > 0)
				item_batch[item_batch.size() - 1].last = 1'b1;
			foreach (item_batch[i])
				expected_results.push_back(item_batch[i]);
		endfunction

		function void check_result(htd_result_t got);
			htd_result_t want;
			if (expected_results.size() == 0) begin
				error_count++;
				if (error_count <= MAX_SHOWN)
					$display("%0t: result with nothing expected: status %0d symbol %02h",
						$time, got.status, got.out_symbol);
				return;
			end
			want = expected_results.pop_front();
			checked_count++;
			status_seen[int'(want.status)]++;
			if (got.status !== want.status || got.out_symbol !== want.out_symbol ||
					got.last !== want.last || got.finished !== want.finished) begin
				error_count++;
				if (error_count <= MAX_SHOWN) begin
					$display("%0t: mismatch: expected status %0d symbol %02h last %b finished %b",
						$time, want.status, want.out_symbol, want.last, want.finished);
					$display("    got status %0d symbol %02h last %b finished %b",
						got.status, got.out_symbol, got.last, got.finished);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	htd_req_if req_ch();
	htd_res_if res_ch();
	htd_cfg_if cfg_ch();

	huffman_tree_decoder_unit #(
		.NODE_COUNT  (NODE_COUNT),
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.res   (res_ch),
		.cfg   (cfg_ch)
	);

	htd_scoreboard sb = new();

	int burst_left = 0;
	int active_items = 0;
	int loads_sent = 0;
	int bytes_sent = 0;

	// Current code book: codes that form a prefix-free tree
	int          book_len [$];
	logic [31:0] book_val [$];
	logic [7:0]  book_sym [$];

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Give up after a generous fixed time
	initial begin
		#4_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Stall the result channel on its own changing pattern
	initial begin
		int seg_left;
		int mode;
		int tick;
		seg_left = 0;
		mode = 0;
		tick = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (seg_left == 0) begin
				mode = $urandom_range(0, 3);
				seg_left = $urandom_range(16, 120);
			end
			seg_left--;
			tick++;
			case (mode)
				0: res_ch.ready = 1'b1;
				1: res_ch.ready = 1'($urandom_range(0, 1));
				2: res_ch.ready = ($urandom_range(0, 5) == 0);
				default: res_ch.ready = (tick % 3) != 0;
			endcase
		end
	end

	// Check every result transaction
	always @(posedge clk) begin
		htd_result_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.status = res_ch.status;
			got.out_symbol = res_ch.out_symbol;
			got.last = res_ch.last;
			got.finished = res_ch.finished;
			sb.check_result(got);
		end
	end

	// Send one request in bursts with random gaps between them
	task automatic send_request(input htd_request_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
			if ($urandom_range(0, 15) == 0)
				gap = 20;
			if (gap > 0) begin
				@(negedge clk);
				req_ch.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		@(negedge clk);
		req_ch.req_type = r.req_type;
		req_ch.entry_symbol = r.entry_symbol;
		req_ch.code_length = r.code_length;
		req_ch.code_value = r.code_value;
		req_ch.data_byte = r.data_byte;
		req_ch.valid = 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		burst_left--;
		sb.note_request(r);
		active_items++;
	endtask

	task automatic send_load(input logic [7:0] sym, input int len, input logic [31:0] code);
		htd_request_t r;
		r.req_type = REQ_LOAD;
		r.entry_symbol = sym;
		r.code_length = len[5:0];
		r.code_value = code;
		r.data_byte = 8'($urandom_range(0, 255));
		loads_sent++;
		send_request(r);
	endtask

	task automatic send_byte(input logic [7:0] value);
		htd_request_t r;
		r.req_type = REQ_DATA;
		r.entry_symbol = 8'($urandom_range(0, 255));
		r.code_length = 6'($urandom_range(0, 63));
		r.code_value = $urandom;
		r.data_byte = value;
		bytes_sent++;
		send_request(r);
	endtask

	// Drop valid, wait for all results, then let the walk settle
	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid = 1'b0;
		burst_left = 0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_output_length(input logic [31:0] value);
		@(negedge clk);
		cfg_ch.data = value;
		cfg_ch.valid = 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_output_length(value);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Reassign symbols of existing codes, mixed with rejected lengths
	task automatic reload_some(input int count);
		int idx;
		int len;
		logic [7:0] sym;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 3) == 0 || book_len.size() == 0) begin
				len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(MAX_CODE_LEN + 1, 63);
				send_load(8'($urandom_range(0, 255)), len, $urandom);
			end else begin
				idx = $urandom_range(0, book_len.size() - 1);
				sym = 8'($urandom_range(0, 255));
				book_sym[idx] = sym;
				send_load(sym, book_len[idx], book_val[idx]);
			end
		end
	endtask

	// Concatenate random codes into bytes, with some noise bytes mixed in
	task automatic send_symbol_stream(input int n_syms);
		logic stream_bits [$];
		logic [7:0] byte_v;
		int idx;
		for (int k = 0; k < n_syms; k++) begin
			idx = $urandom_range(0, book_len.size() - 1);
			for (int i = book_len[idx] - 1; i >= 0; i--)
				stream_bits.push_back(book_val[idx][i]);
		end
		while (stream_bits.size() > 0) begin
			for (int i = 7; i >= 0; i--)
				byte_v[i] = (stream_bits.size() > 0) ? stream_bits.pop_front() :
					1'($urandom_range(0, 1));
			if ($urandom_range(0, 7) == 0)
				byte_v = 8'($urandom_range(0, 255));
			send_byte(byte_v);
		end
	endtask

	// Main sequence
	initial begin
		int leaf_len [$];
		logic [31:0] leaf_val [$];
		int idx;
		int depth;
		int pick;
		int tries;
		logic [31:0] v;
		logic [31:0] limit;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_LOAD;
		req_ch.entry_symbol = 8'h00;
		req_ch.code_length = 6'd0;
		req_ch.code_value = 32'h0;
		req_ch.data_byte = 8'h00;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = 32'h0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Zero output length: bytes are ignored, rejected lengths still answer
		write_output_length(32'h0);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_load(8'hFF, 0, 32'hFFFF_FFFF);
		send_load(8'h00, MAX_CODE_LEN + 1, 32'hFFFF_FFFF);
		send_load(8'hA5, 63, 32'h0);
		wait_idle();
		write_output_length(32'hFFFF_FFFF);

		// Empty tree: every bit is an invalid code
		send_byte(8'hA5);
		// Longest code, then a load mid-walk that turns an inner node into a leaf
		send_load(8'hFF, MAX_CODE_LEN, 32'hFFFF_FFFF);
		send_byte(8'hFF);
		send_load(8'h00, 20, 32'h000F_FFFF);
		send_byte(8'hFF);
		send_byte(8'hF0);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		// Code value with bits set above the code length
		send_load(8'h5A, 12, 32'hFFFF_F000);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h0F);
		wait_idle();

		// Reach the output length in the middle of a byte
		write_output_length(sb.decoded_count + 1);
		send_byte(8'h00);
		send_byte(8'h00);
		wait_idle();
		write_output_length(32'hFFFF_FFFF);

		// Grow a random prefix tree, at most nine levels deep
		active_items = 0;
		leaf_len.push_back(0);
		leaf_val.push_back(32'h0);
		while (leaf_len.size() < 24) begin
			idx = $urandom_range(0, leaf_len.size() - 1);
			if (leaf_len[idx] < 9) begin
				depth = leaf_len[idx];
				v = leaf_val[idx];
				leaf_len[idx] = depth + 1;
				leaf_val[idx] = v << 1;
				leaf_len.push_back(depth + 1);
				leaf_val.push_back((v << 1) | 32'h1);
			end
		end
		// Leave a few codes out so that some paths stay open
		foreach (leaf_len[i]) begin
			if ($urandom_range(0, 9) != 0 || book_len.size() == 0) begin
				book_len.push_back(leaf_len[i]);
				book_val.push_back(leaf_val[i]);
				book_sym.push_back(8'($urandom_range(0, 255)));
			end
		end
		foreach (book_len[i])
			send_load(book_sym[i], book_len[i], book_val[i]);

		// Phases of coded streams under changing output lengths
		while (active_items < RANDOM_ITEMS) begin
			wait_idle();
			pick = $urandom_range(0, 9);
			if (pick < 6)
				limit = 32'hFFFF_FFFF;
			else if (pick < 9)
				limit = sb.decoded_count + $urandom_range(1, 40);
			else
				limit = $urandom_range(0, sb.decoded_count);
			write_output_length(limit);
			if ($urandom_range(0, 2) == 0)
				reload_some($urandom_range(2, 6));
			send_symbol_stream($urandom_range(4, 40));
		end

		// Fill the node pool with long random codes, then keep decoding
		wait_idle();
		write_output_length(32'hFFFF_FFFF);
		tries = 0;
		while (sb.pool_full_predicted < 3 && tries < 60) begin
			send_load(8'($urandom_range(0, 255)), $urandom_range(24, MAX_CODE_LEN), $urandom);
			tries++;
		end
		reload_some(3);
		send_symbol_stream(10);
		wait_idle();

		$display("Sent %0d table loads and %0d compressed bytes; checked %0d results.",
			loads_sent, bytes_sent, sb.checked_count);
		$display("Results: %0d symbols, %0d loaded, %0d pool full, %0d bad length, %0d invalid.",
			sb.status_seen[ST_SYMBOL], sb.status_seen[ST_LOADED],
			sb.status_seen[ST_POOL_FULL], sb.status_seen[ST_BAD_LEN],
			sb.status_seen[ST_INVALID]);
		if (sb.error_count == 0 && sb.outstanding() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/htd_pkg.sv
hw/rtl/htd_if.sv
hw/rtl/htd_ram.sv
hw/rtl/htd_datapath.sv
hw/rtl/htd_ctrl.sv
hw/rtl/huffman_tree_decoder_unit.sv
tb/testbench.sv
